// ===== rtl/block3_integral_image_sum_squares_core_assert.svh =====
// Assertion macros shared by the integral image core.
// Each macro expects clk and rst_n to be visible at the place of use.
`ifndef BLOCK3_INTEGRAL_IMAGE_SUM_SQUARES_CORE_ASSERT_SVH
`define BLOCK3_INTEGRAL_IMAGE_SUM_SQUARES_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define II3_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define II3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ii3_pkg.sv =====
`default_nettype none

package ii3_pkg;

  // Field widths of the streaming interface.
  localparam int PIX_W     = 8;
  localparam int SUM_W     = 32;
  localparam int SQ_W      = 40;
  localparam int COL_OUT_W = 10;
  localparam int CFG_W     = 11;

  // Block geometry: three columns of three pixels.
  localparam int BLOCK_SIZE = 3;
  localparam int PHASE_W    = 2;

  // Widths of the per-column and per-block partial sums.
  localparam int COLS_W    = 10;  // three pixels
  localparam int COLSQ_W   = 18;  // three squared pixels
  localparam int PART_W    = 12;  // nine pixels
  localparam int PART_SQ_W = 20;  // nine squared pixels

  // Line store depth and register reset value.
  localparam int                MAX_BLOCK_COLS_DEF = 1024;
  localparam logic [CFG_W-1:0]  CFG_RESET          = 11'd1024;

  // A completed block on its way from the band accumulator to the line store.
  typedef struct packed {
    logic [SUM_W-1:0]     sum;
    logic [SQ_W-1:0]      sum_sq;
    logic [COL_OUT_W-1:0] block_col;
    logic                 row_last;
    logic                 first_band;
  } blk_t;

endpackage

`default_nettype wire

// ===== rtl/ii3_col_sum.sv =====
`default_nettype none

// Input register stage: squares and sums the three pixels of one column.
module ii3_col_sum (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ii3_pkg::PIX_W-1:0]    pix_top,
  input  wire logic [ii3_pkg::PIX_W-1:0]    pix_mid,
  input  wire logic [ii3_pkg::PIX_W-1:0]    pix_bot,
  input  wire logic                         frame_start,
  input  wire logic                         col_ready,
  output logic                              col_v,
  output logic [ii3_pkg::COLS_W-1:0]        col_sum,
  output logic [ii3_pkg::COLSQ_W-1:0]       col_sq,
  output logic                              col_fs
);

  logic                          col_v_r;
  logic [ii3_pkg::COLS_W-1:0]    col_sum_r, col_sum_nxt;
  logic [ii3_pkg::COLSQ_W-1:0]   col_sq_r, col_sq_nxt;
  logic                          col_fs_r;
  logic                          load;

  // The slot takes a new beat when empty or when its beat moves on.
  assign in_ready = !col_v_r || col_ready;
  assign load     = in_valid && in_ready;

  // Column sum and sum of squares of the three pixels.
  always_comb begin
    col_sum_nxt = ii3_pkg::COLS_W'(pix_top) + ii3_pkg::COLS_W'(pix_mid)
                + ii3_pkg::COLS_W'(pix_bot);
    col_sq_nxt  = ii3_pkg::COLSQ_W'(pix_top) * ii3_pkg::COLSQ_W'(pix_top)
                + ii3_pkg::COLSQ_W'(pix_mid) * ii3_pkg::COLSQ_W'(pix_mid)
                + ii3_pkg::COLSQ_W'(pix_bot) * ii3_pkg::COLSQ_W'(pix_bot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_v_r <= 1'b0;
    end else if (load) begin
      col_v_r <= 1'b1;
    end else if (col_ready) begin
      col_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      col_sum_r <= col_sum_nxt;
      col_sq_r  <= col_sq_nxt;
      col_fs_r  <= frame_start;
    end
  end

  assign col_v   = col_v_r;
  assign col_sum = col_sum_r;
  assign col_sq  = col_sq_r;
  assign col_fs  = col_fs_r;

endmodule

`default_nettype wire

// ===== rtl/ii3_band_acc.sv =====
`default_nettype none

// Band accumulator: gathers three columns into a block and keeps the
// running row sums and the block counter of the current band.
module ii3_band_acc #(
  parameter int MAX_BLOCK_COLS = ii3_pkg::MAX_BLOCK_COLS_DEF,
  localparam int AW = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         col_v,
  output logic                              col_ready,
  input  wire logic [ii3_pkg::COLS_W-1:0]   col_sum,
  input  wire logic [ii3_pkg::COLSQ_W-1:0]  col_sq,
  input  wire logic                         col_fs,
  input  wire logic [ii3_pkg::CFG_W-1:0]    block_cols,
  input  wire logic                         blk_ready,
  output logic                              blk_v,
  output ii3_pkg::blk_t                     blk,
  output logic [AW-1:0]                     blk_idx,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr
);

  localparam int CNT_W = $clog2(MAX_BLOCK_COLS + 1);
  localparam int CMP_W = (CNT_W > ii3_pkg::CFG_W) ? CNT_W : ii3_pkg::CFG_W;

  logic [ii3_pkg::PART_W-1:0]    part_sum_r, part_sum_nxt, base_part, p_sum;
  logic [ii3_pkg::PART_SQ_W-1:0] part_sq_r, part_sq_nxt, base_psq, p_sq;
  logic [ii3_pkg::PHASE_W-1:0]   phase_r, phase_nxt, base_phase, phase_inc;
  logic [ii3_pkg::SUM_W-1:0]     run_sum_r, run_sum_nxt, base_run, run_sum_new;
  logic [ii3_pkg::SQ_W-1:0]      run_sq_r, run_sq_nxt, base_rsq, run_sq_new;
  logic [AW-1:0]                 count_r, count_nxt, base_count;
  logic                          first_r, first_nxt, base_first;
  logic                          blk_v_r;
  ii3_pkg::blk_t                 blk_r;
  logic [AW-1:0]                 blk_idx_r;
  logic [CMP_W-1:0]              cfg_ext, cols_eff;
  logic                          adv, done, last;

  assign col_ready = !blk_v_r || blk_ready;
  assign adv       = col_v && col_ready;

  // A frame start restarts the band state before the column is taken in.
  always_comb begin
    if (col_fs) begin
      base_part  = '0;
      base_psq   = '0;
      base_phase = '0;
      base_run   = '0;
      base_rsq   = '0;
      base_count = '0;
      base_first = 1'b1;
    end else begin
      base_part  = part_sum_r;
      base_psq   = part_sq_r;
      base_phase = phase_r;
      base_run   = run_sum_r;
      base_rsq   = run_sq_r;
      base_count = count_r;
      base_first = first_r;
    end
  end

  // Block count clamped to the line store depth, zero acting as one.
  always_comb begin
    cfg_ext = CMP_W'(block_cols);
    if (cfg_ext == '0) begin
      cols_eff = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_BLOCK_COLS)) begin
      cols_eff = CMP_W'(MAX_BLOCK_COLS);
    end else begin
      cols_eff = cfg_ext;
    end
  end

  // Partial block sums, block completion and running band sums.
  always_comb begin
    p_sum       = base_part + ii3_pkg::PART_W'(col_sum);
    p_sq        = base_psq + ii3_pkg::PART_SQ_W'(col_sq);
    phase_inc   = base_phase + ii3_pkg::PHASE_W'(1);
    done        = (phase_inc == ii3_pkg::PHASE_W'(ii3_pkg::BLOCK_SIZE));
    last        = (CMP_W'(base_count) >= (cols_eff - CMP_W'(1)));
    run_sum_new = base_run + ii3_pkg::SUM_W'(p_sum);
    run_sq_new  = base_rsq + ii3_pkg::SQ_W'(p_sq);
  end

  // Next band state.
  always_comb begin
    part_sum_nxt = p_sum;
    part_sq_nxt  = p_sq;
    phase_nxt    = phase_inc;
    run_sum_nxt  = base_run;
    run_sq_nxt   = base_rsq;
    count_nxt    = base_count;
    first_nxt    = base_first;
    if (done) begin
      part_sum_nxt = '0;
      part_sq_nxt  = '0;
      phase_nxt    = '0;
      if (last) begin
        run_sum_nxt = '0;
        run_sq_nxt  = '0;
        count_nxt   = '0;
        first_nxt   = 1'b0;
      end else begin
        run_sum_nxt = run_sum_new;
        run_sq_nxt  = run_sq_new;
        count_nxt   = base_count + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_sum_r <= '0;
      part_sq_r  <= '0;
      phase_r    <= '0;
      run_sum_r  <= '0;
      run_sq_r   <= '0;
      count_r    <= '0;
      first_r    <= 1'b1;
    end else if (adv) begin
      part_sum_r <= part_sum_nxt;
      part_sq_r  <= part_sq_nxt;
      phase_r    <= phase_nxt;
      run_sum_r  <= run_sum_nxt;
      run_sq_r   <= run_sq_nxt;
      count_r    <= count_nxt;
      first_r    <= first_nxt;
    end
  end

  // A completed block starts the line store read and fills the block slot.
  assign rd_en   = adv && done;
  assign rd_addr = base_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_v_r <= 1'b0;
    end else if (rd_en) begin
      blk_v_r <= 1'b1;
    end else if (blk_ready) begin
      blk_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      blk_r.sum        <= run_sum_new;
      blk_r.sum_sq     <= run_sq_new;
      blk_r.block_col  <= ii3_pkg::COL_OUT_W'(base_count);
      blk_r.row_last   <= last;
      blk_r.first_band <= base_first;
      blk_idx_r        <= base_count;
    end
  end

  assign blk_v   = blk_v_r;
  assign blk     = blk_r;
  assign blk_idx = blk_idx_r;

endmodule

`default_nettype wire

// ===== rtl/ii3_line_out.sv =====
`default_nettype none

// Line store of the previous band's integrals and the output register.
module ii3_line_out #(
  parameter int MAX_BLOCK_COLS = ii3_pkg::MAX_BLOCK_COLS_DEF,
  localparam int AW = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           rd_en,
  input  wire logic [AW-1:0]                  rd_addr,
  input  wire logic                           blk_v,
  input  wire ii3_pkg::blk_t                  blk,
  input  wire logic [AW-1:0]                  blk_idx,
  output logic                                blk_ready,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ii3_pkg::SUM_W-1:0]           out_sum,
  output logic [ii3_pkg::SQ_W-1:0]            out_sum_sq,
  output logic [ii3_pkg::COL_OUT_W-1:0]       out_block_col,
  output logic                                out_row_last
);

  localparam int ENT_W = ii3_pkg::SUM_W + ii3_pkg::SQ_W;

  logic [ENT_W-1:0]                 line_mem_r [MAX_BLOCK_COLS];
  logic [ENT_W-1:0]                 rd_data_r, byp_data_r, above, wr_data;
  logic                             byp_r;
  logic                             wr_en;
  logic [ii3_pkg::SUM_W-1:0]        above_sum, tot_sum;
  logic [ii3_pkg::SQ_W-1:0]         above_sq, tot_sq;
  logic                             out_v_r;
  logic [ii3_pkg::SUM_W-1:0]        out_sum_r;
  logic [ii3_pkg::SQ_W-1:0]         out_sq_r;
  logic [ii3_pkg::COL_OUT_W-1:0]    out_col_r;
  logic                             out_last_r;

  assign blk_ready = !out_v_r || out_ready;
  assign wr_en     = blk_v && blk_ready;

  // Entry from the band above; a write landing in the read cycle is forwarded.
  assign above     = byp_r ? byp_data_r : rd_data_r;
  assign above_sum = above[ii3_pkg::SQ_W +: ii3_pkg::SUM_W];
  assign above_sq  = above[ii3_pkg::SQ_W-1:0];

  // Integral of the block: running band sum plus the entry above, which the first band leaves out.
  always_comb begin
    if (blk.first_band) begin
      tot_sum = blk.sum;
      tot_sq  = blk.sum_sq;
    end else begin
      tot_sum = blk.sum + above_sum;
      tot_sq  = blk.sum_sq + above_sq;
    end
    wr_data = {tot_sum, tot_sq};
  end

  // Line store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem_r[blk_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= line_mem_r[rd_addr];
      byp_r      <= wr_en && (blk_idx == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (wr_en) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_sum_r  <= tot_sum;
      out_sq_r   <= tot_sq;
      out_col_r  <= blk.block_col;
      out_last_r <= blk.row_last;
    end
  end

  assign out_valid     = out_v_r;
  assign out_sum       = out_sum_r;
  assign out_sum_sq    = out_sq_r;
  assign out_block_col = out_col_r;
  assign out_row_last  = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/block3_integral_image_sum_squares_core.sv =====
// Subsampled integral image of pixel sums and sums of squares over 3x3 blocks.
// Each input beat is one column of three pixels of the current band; every
// third column completes a block and yields one output beat carrying the
// block's integrals (sum wraps at 32 bits, sum_sq at 40 bits). The core takes
// one column per clock cycle while the output does not stall; an input beat
// passes the column register, the band accumulator, then the line store and
// the output register. The line store holds MAX_BLOCK_COLS entries of 72 bits
// with one write port and one registered read port; it is not cleared after
// reset. The user must see that the first band writes every entry before any
// later band reads it, and must write block_cols only while the core is idle;
// the core enforces neither. 0 acts as 1 and values above MAX_BLOCK_COLS are
// clamped. Assert in_frame_start on the first column of each frame.
`default_nettype none
`include "block3_integral_image_sum_squares_core_assert.svh"

module block3_integral_image_sum_squares_core #(
  parameter int MAX_BLOCK_COLS = ii3_pkg::MAX_BLOCK_COLS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ii3_pkg::PIX_W-1:0]      in_pix_top,
  input  wire logic [ii3_pkg::PIX_W-1:0]      in_pix_mid,
  input  wire logic [ii3_pkg::PIX_W-1:0]      in_pix_bot,
  input  wire logic                           in_frame_start,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ii3_pkg::SUM_W-1:0]           out_sum,
  output logic [ii3_pkg::SQ_W-1:0]            out_sum_sq,
  output logic [ii3_pkg::COL_OUT_W-1:0]       out_block_col,
  output logic                                out_row_last,
  input  wire logic                           cfg_we,
  input  wire logic [ii3_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int AW = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;

  logic [ii3_pkg::CFG_W-1:0]    block_cols_r;
  logic                         col_v, col_ready, col_fs;
  logic [ii3_pkg::COLS_W-1:0]   col_sum;
  logic [ii3_pkg::COLSQ_W-1:0]  col_sq;
  logic                         blk_v, blk_ready, rd_en;
  ii3_pkg::blk_t                blk;
  logic [AW-1:0]                blk_idx, rd_addr;

  // Block count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_cols_r <= ii3_pkg::CFG_RESET;
    end else if (cfg_we) begin
      block_cols_r <= cfg_wdata;
    end
  end

  ii3_col_sum u_col (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pix_top     (in_pix_top),
    .pix_mid     (in_pix_mid),
    .pix_bot     (in_pix_bot),
    .frame_start (in_frame_start),
    .col_ready   (col_ready),
    .col_v       (col_v),
    .col_sum     (col_sum),
    .col_sq      (col_sq),
    .col_fs      (col_fs)
  );

  ii3_band_acc #(
    .MAX_BLOCK_COLS (MAX_BLOCK_COLS)
  ) u_band (
    .clk        (clk),
    .rst_n      (rst_n),
    .col_v      (col_v),
    .col_ready  (col_ready),
    .col_sum    (col_sum),
    .col_sq     (col_sq),
    .col_fs     (col_fs),
    .block_cols (block_cols_r),
    .blk_ready  (blk_ready),
    .blk_v      (blk_v),
    .blk        (blk),
    .blk_idx    (blk_idx),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  ii3_line_out #(
    .MAX_BLOCK_COLS (MAX_BLOCK_COLS)
  ) u_line (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .blk_v         (blk_v),
    .blk           (blk),
    .blk_idx       (blk_idx),
    .blk_ready     (blk_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sum       (out_sum),
    .out_sum_sq    (out_sum_sq),
    .out_block_col (out_block_col),
    .out_row_last  (out_row_last)
  );

  // A completed block always occupies the block slot in the next cycle.
  `II3_ASSERT_NEXT(a_blk_fill, rd_en, blk_v, "completed block did not reach the block slot")
  // No block completes while the block slot is held by a stalled block.
  `II3_ASSERT_SAME(a_blk_stall, blk_v && !blk_ready, !rd_en, "block completed into a full slot")
  // An output beat appears only after a block was waiting in the slot.
  `II3_ASSERT_SAME(a_out_src, $rose(out_valid), $past(blk_v), "output beat without a block")

endmodule

`default_nettype wire

// ===== test/block3_integral_image_sum_squares_core_tb.sv =====
`timescale 1ns / 100ps

module block3_integral_image_sum_squares_core_tb;

  localparam int               PIX_W      = ii3_pkg::PIX_W;
  localparam int               SUM_W      = ii3_pkg::SUM_W;
  localparam int               SQ_W       = ii3_pkg::SQ_W;
  localparam int               COL_OUT_W  = ii3_pkg::COL_OUT_W;
  localparam int               CFG_W      = ii3_pkg::CFG_W;
  localparam int               BLOCK_SIZE = ii3_pkg::BLOCK_SIZE;
  localparam logic [CFG_W-1:0] CFG_RESET  = ii3_pkg::CFG_RESET;

  localparam int LINE_DEPTH     = ii3_pkg::MAX_BLOCK_COLS_DEF;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int PHASE_CAP      = 360;

  // One block integral as it leaves the core.
  typedef struct packed {
    logic [SUM_W-1:0]     sum;
    logic [SQ_W-1:0]      sum_sq;
    logic [COL_OUT_W-1:0] block_col;
    logic                 row_last;
  } block_integral_t;

  // Tracks the band state of the core and the integrals still owed by it.
  class integral_scoreboard;
    logic [SUM_W-1:0] above_sum [LINE_DEPTH];
    logic [SQ_W-1:0]  above_sq  [LINE_DEPTH];
    bit               stored    [LINE_DEPTH];
    logic [SUM_W-1:0] band_sum;
    logic [SQ_W-1:0]  band_sq;
    int unsigned      blk_sum;
    int unsigned      blk_sq;
    int unsigned      col_idx;
    int unsigned      taken;
    bit               in_first_band;
    logic [CFG_W-1:0] block_cols;
    block_integral_t  pending_integrals[$];
    int               errors;

    function new();
      band_sum      = '0;
      band_sq       = '0;
      blk_sum       = 0;
      blk_sq        = 0;
      col_idx       = 0;
      taken         = 0;
      in_first_band = 1'b1;
      block_cols    = CFG_RESET;
      errors        = 0;
      foreach (stored[i]) stored[i] = 1'b0;
    endfunction

    function void set_block_cols(logic [CFG_W-1:0] v);
      block_cols = v;
    endfunction

    function int unsigned eff_cols();
      int unsigned c;
      c = block_cols;
      if (c == 0) c = 1;
      if (c > LINE_DEPTH) c = LINE_DEPTH;
      return c;
    endfunction

    function int pending();
      return pending_integrals.size();
    endfunction

    function int unsigned line_index();
      return (col_idx >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_idx;
    endfunction

    // True when a plain column now would close a block whose line entry was never written.
    function bit reads_unwritten();
      return taken == BLOCK_SIZE - 1 && !in_first_band && !stored[line_index()];
    endfunction

    // Takes in one accepted column and queues the block integral it completes, if any.
    function void note_column(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
                              logic [PIX_W-1:0] b, logic fs);
      block_integral_t r;
      int unsigned     pt, pm, pb, idx;
      bit              last;
      pt = t;
      pm = m;
      pb = b;
      if (fs) begin
        band_sum      = '0;
        band_sq       = '0;
        blk_sum       = 0;
        blk_sq        = 0;
        col_idx       = 0;
        taken         = 0;
        in_first_band = 1'b1;
      end
      blk_sum += pt + pm + pb;
      blk_sq  += pt * pt + pm * pm + pb * pb;
      taken++;
      if (taken < BLOCK_SIZE) return;

      last     = col_idx >= eff_cols() - 1;
      idx      = line_index();
      band_sum = band_sum + blk_sum;
      band_sq  = band_sq + blk_sq;
      r.sum    = band_sum;
      r.sum_sq = band_sq;
      if (!in_first_band) begin
        r.sum    = r.sum + above_sum[idx];
        r.sum_sq = r.sum_sq + above_sq[idx];
      end
      above_sum[idx] = r.sum;
      above_sq[idx]  = r.sum_sq;
      stored[idx]    = 1'b1;
      r.block_col    = col_idx[COL_OUT_W-1:0];
      r.row_last     = last;
      pending_integrals.push_back(r);

      blk_sum = 0;
      blk_sq  = 0;
      taken   = 0;
      if (last) begin
        col_idx       = 0;
        band_sum      = '0;
        band_sq       = '0;
        in_first_band = 1'b0;
      end else begin
        col_idx++;
      end
    endfunction

    // Compares one output beat with the oldest owed integral.
    function void check_block(block_integral_t got);
      block_integral_t want;
      if (pending_integrals.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output beat: sum=%0d sum_sq=%0d col=%0d last=%0b",
                   got.sum, got.sum_sq, got.block_col, got.row_last);
        return;
      end
      want = pending_integrals.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $write("block mismatch: expected sum=%0d sum_sq=%0d col=%0d last=%0b, ",
                 want.sum, want.sum_sq, want.block_col, want.row_last);
          $display("got sum=%0d sum_sq=%0d col=%0d last=%0b",
                   got.sum, got.sum_sq, got.block_col, got.row_last);
        end
      end
    endfunction
  endclass

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pix_top     = '0;
  logic [PIX_W-1:0]     in_pix_mid     = '0;
  logic [PIX_W-1:0]     in_pix_bot     = '0;
  logic                 in_frame_start = 1'b0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [SUM_W-1:0]     out_sum;
  logic [SQ_W-1:0]      out_sum_sq;
  logic [COL_OUT_W-1:0] out_block_col;
  logic                 out_row_last;
  logic                 cfg_we         = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata      = '0;

  integral_scoreboard sb;
  bit                 in_calm      = 1'b0;
  bit                 out_calm     = 1'b0;
  int                 hold_left    = 0;
  int                 quiet_cycles = 0;

  block3_integral_image_sum_squares_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pix_top    (in_pix_top),
    .in_pix_mid    (in_pix_mid),
    .in_pix_bot    (in_pix_bot),
    .in_frame_start(in_frame_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sum       (out_sum),
    .out_sum_sq    (out_sum_sq),
    .out_block_col (out_block_col),
    .out_row_last  (out_row_last),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Pixels lean toward the extremes so that both ends of the range show up often.
  function automatic logic [PIX_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom);
  endfunction

  // Sends one column beat after an optional gap and records it once accepted.
  task automatic push_column(input logic [PIX_W-1:0] t, input logic [PIX_W-1:0] m,
                             input logic [PIX_W-1:0] b, input logic fs);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // Restart the frame rather than let a later band read a line entry never filled.
    if (!fs && sb.reads_unwritten()) fs = 1'b1;
    in_valid       <= 1'b1;
    in_pix_top     <= t;
    in_pix_mid     <= m;
    in_pix_bot     <= b;
    in_frame_start <= fs;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_column(t, m, b, fs);
  endtask

  task automatic push_random(input logic fs);
    push_column(pick_pixel(), pick_pixel(), pick_pixel(), fs);
  endtask

  // Waits until every owed integral has come out and the pipeline has emptied.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_cols(input logic [CFG_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_block_cols(v);
    cfg_we    <= 1'b0;
  endtask

  // Result side: check each accepted beat, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_block({out_sum, out_sum_sq, out_block_col, out_row_last});
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= 1'b1;
      hold_left = out_calm ? 0 : pick_gap();
    end
  end

  // Watchdog: too many cycles in a row without any beat on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[block3_integral_image_sum_squares_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main
    int               i, n, bands, sel, random_items;
    logic [CFG_W-1:0] cols;
    bit               carry_on, broken;

    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset block count: a full-scale block, a block cut short by a frame start, a dark block.
    for (i = 0; i < 3; i++) push_column('1, '1, '1, 1'b0);
    for (i = 0; i < 2; i++) push_column('1, '0, '1, 1'b0);
    for (i = 0; i < 3; i++) push_column('0, '0, '0, i == 0);

    // A count of zero behaves as one block per band.
    write_block_cols('0);
    for (i = 0; i < 6; i++) push_random(i == 0);

    // Lowering the count mid-band ends the band at the next block.
    write_block_cols(CFG_W'(3));
    for (i = 0; i < 6; i++) push_random(i == 0);
    write_block_cols(CFG_W'(1));
    for (i = 0; i < 6; i++) push_random(1'b0);

    // Wide band at the largest count, then a raise past the line depth.
    write_block_cols(CFG_W'(LINE_DEPTH));
    for (i = 0; i < 300; i++) push_random(i == 0);
    write_block_cols('1);
    for (i = 0; i < 30; i++) push_random(1'b0);

    // Random frames, mostly whole bands, some cut short or restarted at random.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      carry_on = ($urandom_range(0, 4) == 0);
      if (random_items == 0 || $urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 99);
        if (sel < 10)      cols = '0;
        else if (sel < 20) cols = CFG_W'(1);
        else if (sel < 70) cols = CFG_W'($urandom_range(2, 8));
        else if (sel < 90) cols = CFG_W'($urandom_range(9, 40));
        else if (sel < 95) cols = CFG_W'(LINE_DEPTH);
        else               cols = CFG_W'($urandom_range(LINE_DEPTH + 1, 2047));
        write_block_cols(cols);
      end
      in_calm  = ($urandom_range(0, 4) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      bands    = $urandom_range(1, 4);
      n        = bands * sb.eff_cols() * BLOCK_SIZE;
      if (n > PHASE_CAP) n = PHASE_CAP;
      broken = ($urandom_range(0, 4) == 0);
      if (broken) n = $urandom_range(1, n + 5);
      for (i = 0; i < n; i++)
        push_random((i == 0 && !carry_on) || (broken && $urandom_range(0, 49) == 0));
      random_items += n;
    end

    settle();
    if (sb.errors == 0)
      $display("[block3_integral_image_sum_squares_core] OK");
    else
      $display("[block3_integral_image_sum_squares_core] ERROR");
    $finish;
  end

endmodule
